@@ rtl/assert_macros.svh @@
// assertion macros for the waveform generator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PWL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pwl assertion failed");
`define PWL_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pwl assertion failed");
`else
`define PWL_ASSERT(lbl, clk, rst_n, prop)
`define PWL_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

@@ rtl/pwl_pkg.sv @@
// shared types, constants and datapath operation codes
`default_nettype none
package pwl_pkg;

    localparam int MAX_POINTS_DEF  = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int TIME_WIDTH_DEF  = 32;

    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int COUNT_W     = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 4'd1;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
    localparam logic [OP_W-1:0] OP_WRITE     = 5'd1;
    localparam logic [OP_W-1:0] OP_LOAD      = 5'd2;
    localparam logic [OP_W-1:0] OP_SCAN_RD   = 5'd3;
    localparam logic [OP_W-1:0] OP_SCAN_CK   = 5'd4;
    localparam logic [OP_W-1:0] OP_PERIOD    = 5'd5;
    localparam logic [OP_W-1:0] OP_MOD_INIT  = 5'd6;
    localparam logic [OP_W-1:0] OP_MOD_STEP  = 5'd7;
    localparam logic [OP_W-1:0] OP_SRCH_INIT = 5'd8;
    localparam logic [OP_W-1:0] OP_SRCH_RD   = 5'd9;
    localparam logic [OP_W-1:0] OP_SRCH_CK   = 5'd10;
    localparam logic [OP_W-1:0] OP_SEG_RD0   = 5'd11;
    localparam logic [OP_W-1:0] OP_SEG_RD1   = 5'd12;
    localparam logic [OP_W-1:0] OP_SEG_CAP   = 5'd13;
    localparam logic [OP_W-1:0] OP_DIV_INIT  = 5'd14;
    localparam logic [OP_W-1:0] OP_DIV_STEP  = 5'd15;
    localparam logic [OP_W-1:0] OP_ADV_ADD   = 5'd16;
    localparam logic [OP_W-1:0] OP_ADV_SUB   = 5'd17;
    localparam logic [OP_W-1:0] OP_OUT       = 5'd18;

    typedef struct packed {
        logic               func;
        logic [3:0]         entry_index;
        logic [31:0]        entry_time;
        logic signed [31:0] entry_value;
        logic               enable;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               table_error;
    } out_item_t;

    typedef struct packed {
        logic scan_last;
        logic bad;
        logic mod_need;
        logic mod_done;
        logic srch_done;
        logic div_done;
        logic en;
    } dp_status_t;

endpackage
`default_nettype wire

@@ rtl/pwl_dp.sv @@
// datapath: tables, phase, search registers and interpolation divider
`default_nettype none
`include "assert_macros.svh"
module pwl_dp #(
    parameter int MAX_POINTS  = 16,
    parameter int VALUE_WIDTH = 32,
    parameter int TIME_WIDTH  = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [pwl_pkg::OP_W-1:0]        op,
    input  wire pwl_pkg::in_item_t               in_data,
    input  wire logic                            cfg_we,
    input  wire logic [pwl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pwl_pkg::CFG_DATA_W-1:0]  cfg_data,
    output pwl_pkg::dp_status_t                  status,
    output pwl_pkg::out_item_t                   out_data
);
    import pwl_pkg::*;

    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW = IW + 1;
    localparam int TW = TIME_WIDTH;
    localparam int VW = VALUE_WIDTH;
    localparam int PW = TW + 1;
    localparam int MW = VW + 1;
    localparam int MCW = $clog2(PW);
    localparam int DCW = $clog2(MW);

    logic [TW-1:0] t_mem [MAX_POINTS];
    logic [VW-1:0] v_mem [MAX_POINTS];
    logic [TW-1:0] rd_t;
    logic [VW-1:0] rd_v;
    logic [IW-1:0] rd_addr;

    logic [TW-1:0]      step_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [PW-1:0]      phase_reg;
    logic [PW-1:0]      period_reg;
    logic               en_reg;
    logic               bad_reg;
    logic [NW-1:0]      n_reg;
    logic [IW-1:0]      scan_k_reg;
    logic [TW-1:0]      prev_t_reg;
    logic [TW-1:0]      last_t_reg;
    logic [PW-1:0]      mod_r_reg;
    logic [PW-1:0]      mod_sh_reg;
    logic [MCW-1:0]     mod_cnt_reg;
    logic [NW-1:0]      lo_reg;
    logic [NW-1:0]      hi_reg;
    logic [IW-1:0]      mid_reg;
    logic [TW-1:0]      t1_reg;
    logic [TW-1:0]      t2_reg;
    logic [VW-1:0]      v1_reg;
    logic [VW-1:0]      v2_reg;
    logic [PW-1:0]      dt_reg;
    logic [PW-1:0]      den_reg;
    logic [MW-1:0]      mag_reg;
    logic [MW-1:0]      mag_sh_reg;
    logic               neg_reg;
    logic [MW-1:0]      q_reg;
    logic [PW-1:0]      r_reg;
    logic [DCW-1:0]     div_cnt_reg;
    logic [PW:0]        sum_reg;
    out_item_t          out_reg;

    logic [IW-1:0] n_m1;
    logic [IW-1:0] mid;
    logic [NW:0]   lo_hi;
    logic          wrap;
    logic          wr_en;
    logic [PW:0]   mod_t;
    logic [PW+1:0] r2;
    logic [PW+1:0] den2;
    logic [MW-1:0] dv;
    logic [VW-1:0] res;

    assign n_m1  = IW'(n_reg - NW'(1));
    assign lo_hi = (NW+1)'(lo_reg) + (NW+1)'(hi_reg);
    assign mid   = IW'(lo_hi >> 1);
    assign wrap  = (hi_reg == n_reg);
    assign wr_en = (op == OP_WRITE) && (32'(in_data.entry_index) < MAX_POINTS);
    assign mod_t = {mod_r_reg, mod_sh_reg[PW-1]};
    assign r2    = ((PW+2)'(r_reg) << 1) + (mag_sh_reg[MW-1] ? (PW+2)'(dt_reg) : '0);
    assign den2  = (PW+2)'(den_reg) << 1;
    assign dv    = {v2_reg[VW-1], v2_reg} - {v1_reg[VW-1], v1_reg};
    assign res   = neg_reg ? (v1_reg - VW'(q_reg)) : (v1_reg + VW'(q_reg));

    always_comb
    begin
        unique case (op)
            OP_SCAN_RD: rd_addr = scan_k_reg;
            OP_SRCH_RD: rd_addr = mid;
            OP_SEG_RD0: rd_addr = wrap ? n_m1 : IW'(hi_reg - NW'(1));
            OP_SEG_RD1: rd_addr = wrap ? '0 : IW'(hi_reg);
            default:    rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            t_mem[IW'(in_data.entry_index)] <= TW'(in_data.entry_time);
            v_mem[IW'(in_data.entry_index)] <= VW'(unsigned'(in_data.entry_value));
        end
        rd_t <= t_mem[rd_addr];
        rd_v <= v_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= TW'(1);
            count_reg <= COUNT_W'(2);
            phase_reg <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_TIME_STEP)
                step_reg <= TW'(cfg_data);
            if (cfg_we && cfg_index == CFG_POINT_COUNT)
                count_reg <= COUNT_W'(cfg_data);
            if (op == OP_MOD_STEP && mod_cnt_reg == '0)
                phase_reg <= (mod_t >= (PW+1)'(period_reg)) ? PW'(mod_t - (PW+1)'(period_reg))
                                                             : PW'(mod_t);
            if (op == OP_ADV_SUB)
                phase_reg <= (sum_reg >= (PW+1)'(period_reg)) ? PW'(sum_reg - (PW+1)'(period_reg))
                                                              : PW'(sum_reg);
            if (op == OP_SRCH_INIT)
            begin
                lo_reg <= '0;
                hi_reg <= n_reg;
            end
            if (op == OP_SRCH_CK)
            begin
                if (PW'(rd_t) <= phase_reg)
                    lo_reg <= NW'(mid_reg) + NW'(1);
                else
                    hi_reg <= NW'(mid_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_LOAD:
            begin
                en_reg     <= in_data.enable;
                bad_reg    <= (count_reg < COUNT_W'(2)) || (32'(count_reg) > MAX_POINTS)
                              || (step_reg == '0);
                n_reg      <= NW'(count_reg);
                scan_k_reg <= '0;
            end
            OP_SCAN_CK:
            begin
                if (scan_k_reg == '0)
                begin
                    if (rd_t != '0)
                        bad_reg <= 1'b1;
                end
                else if (rd_t <= prev_t_reg)
                    bad_reg <= 1'b1;
                if (scan_k_reg == n_m1 && step_reg > rd_t)
                    bad_reg <= 1'b1;
                prev_t_reg <= rd_t;
                last_t_reg <= rd_t;
                scan_k_reg <= scan_k_reg + IW'(1);
            end
            OP_PERIOD:
                period_reg <= PW'(last_t_reg) + PW'(step_reg);
            OP_MOD_INIT:
            begin
                mod_r_reg   <= '0;
                mod_sh_reg  <= phase_reg;
                mod_cnt_reg <= MCW'(PW - 1);
            end
            OP_MOD_STEP:
            begin
                mod_r_reg   <= (mod_t >= (PW+1)'(period_reg)) ? PW'(mod_t - (PW+1)'(period_reg))
                                                              : PW'(mod_t);
                mod_sh_reg  <= mod_sh_reg << 1;
                mod_cnt_reg <= mod_cnt_reg - MCW'(1);
            end
            OP_SRCH_RD:
                mid_reg <= mid;
            OP_SEG_RD1:
            begin
                t1_reg <= rd_t;
                v1_reg <= rd_v;
            end
            OP_SEG_CAP:
            begin
                t2_reg <= rd_t;
                v2_reg <= rd_v;
            end
            OP_DIV_INIT:
            begin
                dt_reg      <= phase_reg - PW'(t1_reg);
                den_reg     <= wrap ? PW'(step_reg) : (PW'(t2_reg) - PW'(t1_reg));
                neg_reg     <= dv[MW-1];
                mag_reg     <= dv[MW-1] ? (MW'(0) - dv) : dv;
                mag_sh_reg  <= dv[MW-1] ? (MW'(0) - dv) : dv;
                q_reg       <= '0;
                r_reg       <= '0;
                div_cnt_reg <= DCW'(MW - 1);
            end
            OP_DIV_STEP:
            begin
                if (r2 >= den2)
                begin
                    r_reg <= PW'(r2 - den2);
                    q_reg <= (q_reg << 1) + MW'(2);
                end
                else if (r2 >= (PW+2)'(den_reg))
                begin
                    r_reg <= PW'(r2 - (PW+2)'(den_reg));
                    q_reg <= (q_reg << 1) + MW'(1);
                end
                else
                begin
                    r_reg <= PW'(r2);
                    q_reg <= q_reg << 1;
                end
                mag_sh_reg  <= mag_sh_reg << 1;
                div_cnt_reg <= div_cnt_reg - DCW'(1);
            end
            OP_ADV_ADD:
                sum_reg <= (PW+1)'(phase_reg) + (PW+1)'(step_reg);
            OP_OUT:
            begin
                out_reg.sample_value <= (bad_reg || !en_reg) ? '0 : 32'(res);
                out_reg.table_error  <= bad_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status.scan_last = (scan_k_reg == n_m1);
    assign status.bad       = bad_reg;
    assign status.mod_need  = (phase_reg >= period_reg);
    assign status.mod_done  = (mod_cnt_reg == '0);
    assign status.srch_done = (lo_reg == hi_reg);
    assign status.div_done  = (div_cnt_reg == '0);
    assign status.en        = en_reg;
    assign out_data         = out_reg;

    `PWL_ASSERT_NEXT(a_phase_in_period, clk, rst_n, op == OP_ADV_SUB, phase_reg < period_reg)
    `PWL_ASSERT(a_search_order, clk, rst_n, lo_reg <= hi_reg)
    `PWL_ASSERT(a_quot_bound, clk, rst_n, (op == OP_OUT && !bad_reg && en_reg) |-> (q_reg <= mag_reg))

endmodule
`default_nettype wire

@@ rtl/pwl_ctrl.sv @@
// controller state machine sequencing one transaction at a time
`default_nettype none
module pwl_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic                     in_func,
    input  wire logic                     out_stall,
    input  wire pwl_pkg::dp_status_t      status,
    output logic [pwl_pkg::OP_W-1:0]      op,
    output logic                          in_stall,
    output logic                          out_valid
);
    import pwl_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN_RD = 4'd1;
    localparam logic [3:0] S_SCAN_CK = 4'd2;
    localparam logic [3:0] S_CHECK   = 4'd3;
    localparam logic [3:0] S_BRANCH  = 4'd4;
    localparam logic [3:0] S_MOD     = 4'd5;
    localparam logic [3:0] S_SRCH    = 4'd6;
    localparam logic [3:0] S_SRCH_CK = 4'd7;
    localparam logic [3:0] S_SEG1    = 4'd8;
    localparam logic [3:0] S_SEG2    = 4'd9;
    localparam logic [3:0] S_DINIT   = 4'd10;
    localparam logic [3:0] S_DIV     = 4'd11;
    localparam logic [3:0] S_ADV0    = 4'd12;
    localparam logic [3:0] S_ADV1    = 4'd13;
    localparam logic [3:0] S_FIN     = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        op             = OP_NONE;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && in_func == FUNC_WRITE)
                    op = OP_WRITE;
                else if (accept)
                begin
                    op         = OP_LOAD;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                op         = OP_SCAN_RD;
                state_next = S_SCAN_CK;
            end
            S_SCAN_CK:
            begin
                op         = OP_SCAN_CK;
                state_next = status.scan_last ? S_CHECK : S_SCAN_RD;
            end
            S_CHECK:
            begin
                if (status.bad)
                    state_next = S_FIN;
                else
                begin
                    op         = OP_PERIOD;
                    state_next = S_BRANCH;
                end
            end
            S_BRANCH:
            begin
                priority if (status.mod_need)
                begin
                    op         = OP_MOD_INIT;
                    state_next = S_MOD;
                end
                else if (status.en)
                begin
                    op         = OP_SRCH_INIT;
                    state_next = S_SRCH;
                end
                else
                    state_next = S_ADV0;
            end
            S_MOD:
            begin
                op = OP_MOD_STEP;
                if (status.mod_done)
                    state_next = S_BRANCH;
            end
            S_SRCH:
            begin
                if (status.srch_done)
                begin
                    op         = OP_SEG_RD0;
                    state_next = S_SEG1;
                end
                else
                begin
                    op         = OP_SRCH_RD;
                    state_next = S_SRCH_CK;
                end
            end
            S_SRCH_CK:
            begin
                op         = OP_SRCH_CK;
                state_next = S_SRCH;
            end
            S_SEG1:
            begin
                op         = OP_SEG_RD1;
                state_next = S_SEG2;
            end
            S_SEG2:
            begin
                op         = OP_SEG_CAP;
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                op         = OP_DIV_INIT;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                op = OP_DIV_STEP;
                if (status.div_done)
                    state_next = S_ADV0;
            end
            S_ADV0:
            begin
                op         = OP_ADV_ADD;
                state_next = S_ADV1;
            end
            S_ADV1:
            begin
                op         = OP_ADV_SUB;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    op             = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/periodic_pwl_waveform_generator.sv @@
// top level of the periodic piecewise-linear waveform generator
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_data (func, entry, enable)
//  out     | output    | out_valid/out_stall| out_data (sample, error flag)
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// a table write leaves the controller idle; a tick scans the whole table, reduces the phase
// when it is not below the period, runs the binary search of at most floor(log2(point_count)) + 1
// steps and interpolates with the one-bit-per-cycle divider; a disabled tick skips the search
// and the divider, and an invalid table ends the tick after the scan, leaving the phase unchanged
// reset clears the phase, sets time_step to 1 and point_count to 2; tables are not cleared
// a stalled result holds in the output register while the next transaction is taken
`default_nettype none
module periodic_pwl_waveform_generator #(
    parameter int MAX_POINTS  = pwl_pkg::MAX_POINTS_DEF,
    parameter int VALUE_WIDTH = pwl_pkg::VALUE_WIDTH_DEF,
    parameter int TIME_WIDTH  = pwl_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire pwl_pkg::in_item_t               in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output pwl_pkg::out_item_t                   out_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pwl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pwl_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pwl_pkg::*;

    logic [OP_W-1:0] op;
    dp_status_t      status;

    assign cfg_ready = 1'b1;

    pwl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_func   (in_data.func),
        .out_stall (out_stall),
        .status    (status),
        .op        (op),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    pwl_dp #(
        .MAX_POINTS  (MAX_POINTS),
        .VALUE_WIDTH (VALUE_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

@@ sim/pwl_sample_monitor.sv @@
// predicts waveform samples from accepted transactions and checks every result
`default_nettype none
module pwl_sample_monitor
    import pwl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire in_item_t              in_data,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire out_item_t             out_data,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0]        bp_time [16];
    logic signed [31:0] bp_value [16];
    logic [63:0]        phase;
    logic [31:0]        step;
    logic [4:0]         npts;
    out_item_t          sample_q [$];

    function automatic bit table_ok();
        if (npts < 2 || npts > 16)
            return 0;
        if (bp_time[0] != 0)
            return 0;
        for (int i = 0; i + 1 < npts; i++)
            if (bp_time[i] >= bp_time[i+1])
                return 0;
        if (step == 0 || step > bp_time[npts-1])
            return 0;
        return 1;
    endfunction

    function automatic logic signed [31:0] lerp(logic signed [31:0] v1, logic signed [31:0] v2,
                                                logic [63:0] dt, logic [63:0] den);
        longint     dv;
        bit [127:0] mag;
        bit [127:0] q;
        longint     res;
        dv  = longint'(v2) - longint'(v1);
        mag = (dv < 0) ? 128'(-dv) : 128'(dv);
        q   = (mag * dt) / den;
        res = (dv < 0) ? longint'(v1) - longint'(q[63:0]) : longint'(v1) + longint'(q[63:0]);
        return res[31:0];
    endfunction

    function automatic out_item_t next_sample(logic en);
        out_item_t   r;
        logic [63:0] last;
        logic [63:0] period;
        int          lo;
        int          hi;
        int          mid;
        logic signed [31:0] s;
        r = '0;
        if (!table_ok())
        begin
            r.table_error = 1'b1;
            return r;
        end
        last   = bp_time[npts-1];
        period = last + step;
        if (phase >= period)
            phase = phase % period;
        lo = 0;
        hi = npts;
        while (lo != hi)
        begin
            mid = (lo + hi) / 2;
            if (bp_time[mid] <= phase)
                lo = mid + 1;
            else
                hi = mid;
        end
        if (hi >= npts)
            s = lerp(bp_value[npts-1], bp_value[0], phase - last, step);
        else
            s = lerp(bp_value[hi-1], bp_value[hi], phase - bp_time[hi-1],
                     bp_time[hi] - bp_time[hi-1]);
        r.sample_value = en ? s : '0;
        phase = phase + step;
        if (phase >= period)
            phase = phase - period;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            phase      = '0;
            step       = 32'd1;
            npts       = 5'd2;
            sample_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (sample_q.size() == 0)
                begin
                    $error("unexpected result transaction: sample_value %0d", out_data.sample_value);
                    fail_count++;
                end
                else
                begin
                    want = sample_q.pop_front();
                    if (out_data.sample_value !== want.sample_value)
                    begin
                        $error("sample_value: expected %0d, actual %0d",
                               want.sample_value, out_data.sample_value);
                        fail_count++;
                    end
                    if (out_data.table_error !== want.table_error)
                    begin
                        $error("table_error: expected %0d, actual %0d",
                               want.table_error, out_data.table_error);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_TIME_STEP)
                    step = cfg_data;
                else if (cfg_index == CFG_POINT_COUNT)
                    npts = cfg_data[4:0];
            end
            if (in_valid && !in_stall)
            begin
                if (in_data.func == FUNC_WRITE)
                begin
                    bp_time[in_data.entry_index]  = in_data.entry_time;
                    bp_value[in_data.entry_index] = in_data.entry_value;
                end
                else
                    sample_q.push_back(next_sample(in_data.enable));
            end
            pending = sample_q.size();
        end
    end
endmodule
`default_nettype wire

@@ sim/periodic_pwl_waveform_generator_tb.sv @@
// stimulus, clock, reset and verdict for the waveform generator testbench
`default_nettype none
module periodic_pwl_waveform_generator_tb;
    import pwl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd9;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int NUM_PHASES  = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    cycles;
    bit                    quiet;
    bit                    hold_req;

    periodic_pwl_waveform_generator u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    pwl_sample_monitor u_monitor (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("periodic_pwl_waveform_generator: mismatch");
                $finish;
            end
        end
    end

    // result side back-pressure
    initial
    begin
        out_stall = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    task automatic send_item(in_item_t item);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        forever
        begin
            @(negedge clk);
            if (!in_stall)
                break;
        end
        @(posedge clk);
    endtask

    task automatic put_point(logic [3:0] idx, logic [31:0] t, logic [31:0] v);
        in_item_t item;
        item             = in_item_t'({$urandom, $urandom});
        item.func        = FUNC_WRITE;
        item.entry_index = idx;
        item.entry_time  = t;
        item.entry_value = v;
        send_item(item);
    endtask

    task automatic tick(logic en);
        in_item_t item;
        item        = in_item_t'({$urandom, $urandom});
        item.func   = FUNC_TICK;
        item.enable = en;
        send_item(item);
    endtask

    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        forever
        begin
            @(negedge clk);
            if (cfg_ready)
                break;
        end
        @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] bp_t [16];
        logic [31:0] bp_v [16];
        logic [31:0] gap_max;
        logic [31:0] last;
        logic [31:0] step;
        int          n;
        int          r;
        int          k;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-swing first segment, then fill the rest of the table
        put_point(4'd0, 32'd0, 32'h7FFF_FFFF);
        put_point(4'd1, 32'hFFFF_FFFF, 32'h8000_0000);
        for (int i = 2; i < 16; i++)
            put_point(4'(i), 32'(i * 1000), 32'(i));
        tick(1'b1);
        tick(1'b0);
        tick(1'b1);
        put_point(4'd1, 32'd0, 32'd5);
        tick(1'b1);
        put_point(4'd0, 32'd7, 32'hFFFF_FFFF);
        tick(1'b1);
        drain();
        reg_write(CFG_UNUSED, $urandom);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            quiet = (p == NUM_PHASES - 1);
            n = (p == 0) ? 2 : (p == 1 || p == 2) ? 16 : $urandom_range(2, 16);
            gap_max = (p % 2 == 1) ? 32'd50 : 32'hFFFF_FFFF / n - 1;
            bp_t[0] = '0;
            for (int i = 1; i < n; i++)
                bp_t[i] = bp_t[i-1] + 1 + $urandom_range(0, gap_max);
            if (p == 2)
                bp_t[n-1] = 32'hFFFF_FFFF;
            for (int i = 0; i < n; i++)
                bp_v[i] = ($urandom_range(0, 7) == 0) ?
                          ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000) : $urandom;
            last = bp_t[n-1];
            if (p == 2)
                step = 32'hFFFF_FFFF;
            else if (p == 3)
                step = 32'd1;
            else if (p == 5)
                step = last + 1;
            else
                step = $urandom_range(1, last);
            reg_write(CFG_TIME_STEP, step);
            reg_write(CFG_POINT_COUNT, 32'(n));
            for (int i = 0; i < n; i++)
                put_point(4'(i), bp_t[i], bp_v[i]);
            if (p == 4)
                hold_req = 1'b1;
            for (int j = 0; j < 200; j++)
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    put_point(4'($urandom), $urandom, $urandom);
                else if (r == 1)
                begin
                    k = $urandom_range(0, n - 1);
                    put_point(4'(k), bp_t[k], bp_v[k]);
                end
                else
                    tick($urandom_range(0, 7) != 0);
            end
            drain();
        end

        if (fail_count == 0)
            $display("periodic_pwl_waveform_generator: match");
        else
            $display("periodic_pwl_waveform_generator: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

@@ periodic_pwl_waveform_generator.f @@
+incdir+rtl
rtl/pwl_pkg.sv
rtl/pwl_dp.sv
rtl/pwl_ctrl.sv
rtl/periodic_pwl_waveform_generator.sv
sim/pwl_sample_monitor.sv
sim/periodic_pwl_waveform_generator_tb.sv
